>>> rtl/vpu_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpu_pkg
// Shared widths, defaults and the payload carried along the divider cells
// of the vector projection unit.
// ---------------------------------------------------------------------------
package vpu_pkg;

	localparam int DATA_W        = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int DOT_W         = 2 * DATA_W + 1;
	localparam int MSQ_W         = 2 * DATA_W;
	localparam int REM_W         = MSQ_W;
	localparam int Q_W           = DATA_W + 1;
	localparam int PROD_W        = 2 * DATA_W;

	typedef struct packed {
		logic [REM_W-1:0]         rem;
		logic [Q_W-1:0]           nlo;
		logic [MSQ_W-1:0]         msq;
		logic [Q_W-1:0]           quo;
		logic                     neg;
		logic                     zero;
		logic                     ovf;
		logic signed [DATA_W-1:0] bx;
		logic signed [DATA_W-1:0] by;
	} cell_t;

endpackage
`default_nettype wire

>>> rtl/vpu_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpu_front
// Forms the dot product and the squared length of b, takes the magnitude of
// the dot product and prepares the scaled dividend for the divider cells.
// ---------------------------------------------------------------------------
module vpu_front import vpu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_vld,
	output logic                          in_rdy,
	input  wire logic signed [DATA_W-1:0] a_x,
	input  wire logic signed [DATA_W-1:0] a_y,
	input  wire logic signed [DATA_W-1:0] b_x,
	input  wire logic signed [DATA_W-1:0] b_y,
	output logic                          out_vld,
	input  wire logic                     out_rdy,
	output cell_t                         out_cell
);

	localparam int NUM_W = MSQ_W + FRAC_BITS;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic                     rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic signed [PROD_W-1:0] pxx_s1, pyy_s1, qxx_s1, qyy_s1;
	logic signed [DATA_W-1:0] bx_s1, by_s1, bx_s2, by_s2, bx_s3, by_s3;
	logic signed [DOT_W-1:0]  dot_s2;
	logic [MSQ_W-1:0]         msq_s2, msq_s3;
	logic [MSQ_W-1:0]         mag_s3;
	logic                     neg_s3, zero_s3;
	logic [NUM_W-1:0]         num;
	logic [REM_W-1:0]         hi;
	cell_t                    cell_s4;

	assign rdy_s4 = !vld_s4 || out_rdy;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_rdy = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	assign num = {mag_s3, {FRAC_BITS{1'b0}}};
	assign hi  = REM_W'(num[NUM_W-1:Q_W]);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_vld) begin
			pxx_s1 <= a_x * b_x;
			pyy_s1 <= a_y * b_y;
			qxx_s1 <= b_x * b_x;
			qyy_s1 <= b_y * b_y;
			bx_s1  <= b_x;
			by_s1  <= b_y;
		end
		if (rdy_s2 && vld_s1) begin
			dot_s2 <= DOT_W'(pxx_s1) + DOT_W'(pyy_s1);
			msq_s2 <= MSQ_W'(qxx_s1) + MSQ_W'(qyy_s1);
			bx_s2  <= bx_s1;
			by_s2  <= by_s1;
		end
		if (rdy_s3 && vld_s2) begin
			neg_s3  <= dot_s2[DOT_W-1];
			mag_s3  <= dot_s2[DOT_W-1] ? MSQ_W'(-dot_s2) : MSQ_W'(dot_s2);
			zero_s3 <= (msq_s2 == '0);
			msq_s3  <= msq_s2;
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;
		end
		if (rdy_s4 && vld_s3) begin
			cell_s4.rem  <= hi;
			cell_s4.nlo  <= num[Q_W-1:0];
			cell_s4.msq  <= msq_s3;
			cell_s4.quo  <= '0;
			cell_s4.neg  <= neg_s3;
			cell_s4.zero <= zero_s3;
			cell_s4.ovf  <= (hi >= msq_s3);
			cell_s4.bx   <= bx_s3;
			cell_s4.by   <= by_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign out_cell = cell_s4;

endmodule
`default_nettype wire

>>> rtl/vpu_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpu_div_cell
// One restoring division step: brings down the next dividend bit, subtracts
// the divisor when it fits and shifts one quotient bit in.
// ---------------------------------------------------------------------------
module vpu_div_cell import vpu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_vld,
	output logic       in_rdy,
	input  wire cell_t in_cell,
	output logic       out_vld,
	input  wire logic  out_rdy,
	output cell_t      out_cell
);

	logic [REM_W:0]   trial;
	logic [REM_W-1:0] diff;
	logic             fits;
	logic             vld_q;
	cell_t            nxt;
	cell_t            cell_q;

	assign trial = {in_cell.rem, in_cell.nlo[Q_W-1]};
	assign fits  = (trial >= {1'b0, in_cell.msq});
	assign diff  = fits ? REM_W'(trial - {1'b0, in_cell.msq}) : trial[REM_W-1:0];

	always_comb begin
		nxt     = in_cell;
		nxt.rem = diff;
		nxt.nlo = {in_cell.nlo[Q_W-2:0], 1'b0};
		nxt.quo = {in_cell.quo[Q_W-2:0], fits};
	end

	assign in_rdy = !vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			cell_q <= nxt;
		end
	end

	assign out_vld  = vld_q;
	assign out_cell = cell_q;

endmodule
`default_nettype wire

>>> rtl/vpu_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vpu_back
// Signs and clamps the ratio, scales b by it, shifts out the fraction and
// clamps each component into the output register.
// ---------------------------------------------------------------------------
module vpu_back import vpu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	output logic                     in_rdy,
	input  wire cell_t               in_cell,
	output logic                     out_vld,
	input  wire logic                out_rdy,
	output logic signed [DATA_W-1:0] proj_x,
	output logic signed [DATA_W-1:0] proj_y,
	output logic                     zero_direction,
	output logic                     saturated
);

	localparam logic [Q_W-1:0]          POS_LIM = Q_W'((1 << (DATA_W - 1)) - 1);
	localparam logic [Q_W-1:0]          NEG_LIM = Q_W'(1 << (DATA_W - 1));
	localparam logic signed [DATA_W-1:0] MAX_V  = DATA_W'((1 << (DATA_W - 1)) - 1);
	localparam logic signed [DATA_W-1:0] MIN_V  = DATA_W'(1 << (DATA_W - 1));
	localparam logic signed [PROD_W-1:0] MAX_W  = PROD_W'(MAX_V);
	localparam logic signed [PROD_W-1:0] MIN_W  = PROD_W'(MIN_V);

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     rdy_s1, rdy_s2, rdy_s3;
	logic                     rsat;
	logic [Q_W-1:0]           qneg;
	logic signed [DATA_W-1:0] r_s1;
	logic                     rsat_s1, zero_s1, rsat_s2, zero_s2;
	logic signed [DATA_W-1:0] bx_s1, by_s1;
	logic signed [PROD_W-1:0] prx_s2, pry_s2;
	logic signed [PROD_W-1:0] shx, shy;
	logic                     hix, lox, hiy, loy;
	logic signed [DATA_W-1:0] px_s3, py_s3;
	logic                     zero_s3, sat_s3;

	assign rdy_s3 = !vld_s3 || out_rdy;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_rdy = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	assign rsat = in_cell.ovf || (!in_cell.neg && (in_cell.quo > POS_LIM)) ||
		(in_cell.neg && (in_cell.quo > NEG_LIM));
	assign qneg = -in_cell.quo;

	assign shx = prx_s2 >>> FRAC_BITS;
	assign shy = pry_s2 >>> FRAC_BITS;
	assign hix = (shx > MAX_W);
	assign lox = (shx < MIN_W);
	assign hiy = (shy > MAX_W);
	assign loy = (shy < MIN_W);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_vld) begin
			if (rsat) begin
				r_s1 <= in_cell.neg ? MIN_V : MAX_V;
			end else begin
				r_s1 <= in_cell.neg ? qneg[DATA_W-1:0] : in_cell.quo[DATA_W-1:0];
			end
			rsat_s1 <= rsat;
			zero_s1 <= in_cell.zero;
			bx_s1   <= in_cell.bx;
			by_s1   <= in_cell.by;
		end
		if (rdy_s2 && vld_s1) begin
			prx_s2  <= r_s1 * bx_s1;
			pry_s2  <= r_s1 * by_s1;
			rsat_s2 <= rsat_s1;
			zero_s2 <= zero_s1;
		end
		if (rdy_s3 && vld_s2) begin
			if (zero_s2) begin
				px_s3 <= '0;
				py_s3 <= '0;
			end else begin
				px_s3 <= hix ? MAX_V : (lox ? MIN_V : shx[DATA_W-1:0]);
				py_s3 <= hiy ? MAX_V : (loy ? MIN_V : shy[DATA_W-1:0]);
			end
			zero_s3 <= zero_s2;
			sat_s3  <= !zero_s2 && (rsat_s2 || hix || lox || hiy || loy);
		end
	end

	assign out_vld        = vld_s3;
	assign proj_x         = px_s3;
	assign proj_y         = py_s3;
	assign zero_direction = zero_s3;
	assign saturated      = sat_s3;

endmodule
`default_nettype wire

>>> rtl/vector2_projection_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vector2_projection_unit
// Projects vector a onto direction b in signed fixed point, with a pipelined
// restoring divider built as a row of division cells.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Fields
//  in       in_valid / in_ready    a_x, a_y, b_x, b_y
//  out      out_valid / out_ready  proj_x, proj_y, zero_direction, saturated
//
// One item enters per cycle while out_ready keeps the stages moving; each item
// passes 24 registers before its result is offered: 4 front stages, 17 division
// cells (one quotient bit each) and 3 back stages. Reset clears only the
// valid bits of the stages. A stalled output holds its result while the
// stages behind it keep filling; in_ready drops only when every stage holds
// an item.
module vector2_projection_unit import vpu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] a_x,
	input  wire logic signed [DATA_W-1:0] a_y,
	input  wire logic signed [DATA_W-1:0] b_x,
	input  wire logic signed [DATA_W-1:0] b_y,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      proj_x,
	output logic signed [DATA_W-1:0]      proj_y,
	output logic                          zero_direction,
	output logic                          saturated
);

	cell_t cells [0:Q_W];
	logic  vlds  [0:Q_W];
	logic  rdys  [0:Q_W];

	vpu_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_valid),
		.in_rdy   (in_ready),
		.a_x      (a_x),
		.a_y      (a_y),
		.b_x      (b_x),
		.b_y      (b_y),
		.out_vld  (vlds[0]),
		.out_rdy  (rdys[0]),
		.out_cell (cells[0])
	);

	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		vpu_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vlds[i]),
			.in_rdy   (rdys[i]),
			.in_cell  (cells[i]),
			.out_vld  (vlds[i+1]),
			.out_rdy  (rdys[i+1]),
			.out_cell (cells[i+1])
		);
	end

	vpu_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_vld         (vlds[Q_W]),
		.in_rdy         (rdys[Q_W]),
		.in_cell        (cells[Q_W]),
		.out_vld        (out_valid),
		.out_rdy        (out_ready),
		.proj_x         (proj_x),
		.proj_y         (proj_y),
		.zero_direction (zero_direction),
		.saturated      (saturated)
	);

endmodule
`default_nettype wire

>>> bench/projection_checker.sv
// ---------------------------------------------------------------------------
// projection_checker
// Watches both channels of the vector projection unit. Every accepted input
// item is run through a fixed-point projection predictor, and the expected
// result is queued; every accepted result is compared field by field with
// the oldest entry. Failures and the number of results still owed are handed
// to the testbench top.
// ---------------------------------------------------------------------------
module projection_checker import vpu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [DATA_W-1:0] a_x,
	input  logic signed [DATA_W-1:0] a_y,
	input  logic signed [DATA_W-1:0] b_x,
	input  logic signed [DATA_W-1:0] b_y,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [DATA_W-1:0] proj_x,
	input  logic signed [DATA_W-1:0] proj_y,
	input  logic                     zero_direction,
	input  logic                     saturated,
	output int                       fail_count,
	output int                       owed_count
);

	typedef struct packed {
		logic signed [DATA_W-1:0] px;
		logic signed [DATA_W-1:0] py;
		logic                     zero_dir;
		logic                     sat;
	} proj_result_t;

	proj_result_t expected_proj[$];

	function automatic longint clamp_q16(input longint v, inout logic hit);
		if (v > 32767) begin
			hit = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			hit = 1'b1;
			return -32768;
		end
		return v;
	endfunction

	function automatic proj_result_t project_onto_b(
		input logic signed [DATA_W-1:0] ax,
		input logic signed [DATA_W-1:0] ay,
		input logic signed [DATA_W-1:0] bx,
		input logic signed [DATA_W-1:0] by
	);
		longint dot;
		longint msq;
		longint ratio;
		longint cx;
		longint cy;
		logic hit;
		proj_result_t res;
		res = '0;
		hit = 1'b0;
		dot = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
		msq = longint'(bx) * longint'(bx) + longint'(by) * longint'(by);
		if (msq == 0) begin
			res.zero_dir = 1'b1;
		end else begin
			// The ratio truncates toward zero; the components round toward
			// minus infinity through the arithmetic shift.
			ratio = (dot * (longint'(1) <<< FRAC_BITS)) / msq;
			ratio = clamp_q16(ratio, hit);
			cx = clamp_q16((ratio * longint'(bx)) >>> FRAC_BITS, hit);
			cy = clamp_q16((ratio * longint'(by)) >>> FRAC_BITS, hit);
			res.px = cx[DATA_W-1:0];
			res.py = cy[DATA_W-1:0];
			res.sat = hit;
		end
		return res;
	endfunction

	initial begin
		fail_count = 0;
		owed_count = 0;
	end

	always @(posedge clk) begin
		proj_result_t want;
		if (in_valid && in_ready)
			expected_proj.push_back(project_onto_b(a_x, a_y, b_x, b_y));
		if (out_valid && out_ready) begin
			if (expected_proj.size() == 0) begin
				if (fail_count < 10)
					$display("ERROR: result with none expected: proj=(%0d,%0d) zd=%b sat=%b",
						proj_x, proj_y, zero_direction, saturated);
				fail_count++;
			end else begin
				want = expected_proj.pop_front();
				if (proj_x !== want.px || proj_y !== want.py ||
						zero_direction !== want.zero_dir || saturated !== want.sat) begin
					if (fail_count < 10)
						$display("ERROR: expected proj=(%0d,%0d) zd=%b sat=%b, got proj=(%0d,%0d) zd=%b sat=%b",
							want.px, want.py, want.zero_dir, want.sat,
							proj_x, proj_y, zero_direction, saturated);
					fail_count++;
				end
			end
		end
		owed_count = expected_proj.size();
	end

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives vector pairs into the vector projection unit: a directed set of
// corner cases, then random pairs weighted toward zero, short, small and on-axis
// direction vectors. The sender works in bursts and the receiver stalls in
// changing patterns; the checker beside the block predicts every result.
// ---------------------------------------------------------------------------
module testbench import vpu_pkg::*;;

	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;
	typedef enum int {PAIR_ZERO_DIR, PAIR_SHORT_DIR, PAIR_SMALL, PAIR_AXIS, PAIR_FULL} pair_kind_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [DATA_W-1:0] a_x;
	logic signed [DATA_W-1:0] a_y;
	logic signed [DATA_W-1:0] b_x;
	logic signed [DATA_W-1:0] b_y;
	logic out_valid;
	logic out_ready;
	logic signed [DATA_W-1:0] proj_x;
	logic signed [DATA_W-1:0] proj_y;
	logic zero_direction;
	logic saturated;
	int fail_count;
	int owed_count;
	int idle_cycles;
	int burst_left;

	vector2_projection_unit #(.FRAC_BITS(FRAC_BITS_DEF)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.proj_x(proj_x), .proj_y(proj_y),
		.zero_direction(zero_direction), .saturated(saturated)
	);

	projection_checker #(.FRAC_BITS(FRAC_BITS_DEF)) checker_i (
		.clk(clk),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.proj_x(proj_x), .proj_y(proj_y),
		.zero_direction(zero_direction), .saturated(saturated),
		.fail_count(fail_count), .owed_count(owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] rand_within(input int lim);
		return DATA_W'($urandom_range(0, 2 * lim) - lim);
	endfunction

	task automatic send_pair(
		input logic signed [DATA_W-1:0] ax,
		input logic signed [DATA_W-1:0] ay,
		input logic signed [DATA_W-1:0] bx,
		input logic signed [DATA_W-1:0] by
	);
		in_valid <= 1'b1;
		a_x <= ax;
		a_y <= ay;
		b_x <= bx;
		b_y <= by;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 60);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_random_pair();
		pair_kind_t kind;
		logic signed [DATA_W-1:0] bx;
		logic signed [DATA_W-1:0] by;
		kind = pair_kind_t'($urandom_range(0, 9) > 4 ? PAIR_FULL : $urandom_range(0, 3));
		case (kind)
			PAIR_ZERO_DIR: begin
				bx = '0;
				by = '0;
			end
			PAIR_SHORT_DIR: begin
				bx = rand_within(4);
				by = rand_within(4);
			end
			PAIR_SMALL: begin
				bx = rand_within(1024);
				by = rand_within(1024);
			end
			PAIR_AXIS: begin
				bx = ($urandom_range(0, 1) == 1) ? DATA_W'($urandom) : '0;
				by = (bx == 0) ? DATA_W'($urandom) : '0;
			end
			default: begin
				bx = DATA_W'($urandom);
				by = DATA_W'($urandom);
			end
		endcase
		if (kind == PAIR_SMALL)
			send_pair(rand_within(1024), rand_within(1024), bx, by);
		else
			send_pair(DATA_W'($urandom), DATA_W'($urandom), bx, by);
	endtask

	initial begin
		rx_mode_t mode;
		int phase;
		out_ready <= 1'b0;
		@(posedge arst_n);
		phase = 0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 150)) begin
				@(posedge clk);
				phase++;
				case (mode)
					RX_ALWAYS:   out_ready <= 1'b1;
					RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE:   out_ready <= ($urandom_range(0, 9) < 3);
					RX_PERIODIC: out_ready <= ((phase % 7) < 3);
					default:     out_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		burst_left = $urandom_range(1, 60);
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		a_x <= '0;
		a_y <= '0;
		b_x <= '0;
		b_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero direction with assorted and extreme a.
		send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_pair(16'sh7fff, -16'sh8000, 16'sd0, 16'sd0);
		send_pair(-16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
		// Ratio clamps high and low on a tiny direction.
		send_pair(16'sh7fff, 16'sd0, 16'sd1, 16'sd0);
		send_pair(-16'sh8000, 16'sd0, 16'sd1, 16'sd0);
		send_pair(16'sh7fff, 16'sh7fff, 16'sd1, 16'sd1);
		send_pair(16'sd0, -16'sh8000, 16'sd0, -16'sd1);
		// A component clamps while the ratio stays in range.
		send_pair(16'sh7fff, 16'sh7fff, 16'sd512, 16'sd256);
		send_pair(-16'sh8000, -16'sh8000, 16'sd512, 16'sd256);
		send_pair(16'sh7fff, 16'sh7fff, -16'sd256, -16'sd512);
		// Truncation of the ratio against flooring of the components.
		send_pair(-16'sd1, 16'sd0, 16'sd3, 16'sd0);
		send_pair(-16'sd1, 16'sd0, 16'sd1, 16'sd0);
		send_pair(-16'sd1, 16'sd0, 16'sd256, 16'sd0);
		send_pair(16'sd1, 16'sd1, 16'sd3, -16'sd5);
		// Extreme directions.
		send_pair(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
		send_pair(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000);
		send_pair(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
		send_pair(16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff);
		send_pair(16'sd256, 16'sd256, 16'sd256, 16'sd0);
		send_pair(16'sd512, -16'sd768, 16'sd0, 16'sd256);

		repeat (RANDOM_ITEMS) send_random_pair();

		in_valid <= 1'b0;
		while (owed_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && owed_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
